[sv/ksrs_pkg.sv]
`default_nettype none

package ksrs_pkg;

    localparam int STACK_DEPTH = 16;
    localparam int IDX_W       = $clog2(STACK_DEPTH);
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
    localparam int OP_W        = 3;
    localparam int KEY_W       = 8;
    localparam int PAYLOAD_W   = 32;
    localparam int STATUS_W    = 2;
    localparam int FILL_W      = 5;

    typedef enum logic [OP_W-1:0] {
        OP_PUSH    = 3'd0,
        OP_POP     = 3'd1,
        OP_PEEK    = 3'd2,
        OP_REVERSE = 3'd3,
        OP_SORT    = 3'd4
    } t_opcode;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK    = 2'd0,
        STAT_EMPTY = 2'd1,
        STAT_FULL  = 2'd2
    } t_status;

    typedef enum logic {
        S_IDLE,
        S_SORT
    } t_state;

    typedef enum logic [2:0] {
        CELL_HOLD,
        CELL_SHIFT_DOWN,
        CELL_SHIFT_UP,
        CELL_LOAD_TAG,
        CELL_SWAP
    } t_cell_op;

    typedef struct packed {
        t_cell_op op;
        logic     from_below;
        logic     from_above;
    } t_cell_ctl;

    typedef struct packed {
        logic [KEY_W-1:0]     key;
        logic [PAYLOAD_W-1:0] payload;
        logic [IDX_W-1:0]     tag;
    } t_cell_data;

endpackage

`default_nettype wire

[sv/ksrs_if.sv]
`default_nettype none

interface ksrs_in_if import ksrs_pkg::*;;
    logic                 valid;
    logic                 ready;
    logic [OP_W-1:0]      opcode;
    logic [KEY_W-1:0]     entry_key;
    logic [PAYLOAD_W-1:0] entry_payload;

    modport source(output valid, opcode, entry_key, entry_payload, input ready);
    modport sink(input valid, opcode, entry_key, entry_payload, output ready);
endinterface

interface ksrs_out_if import ksrs_pkg::*;;
    logic                 valid;
    logic                 ready;
    logic [STATUS_W-1:0]  status;
    logic [KEY_W-1:0]     out_key;
    logic [PAYLOAD_W-1:0] out_payload;
    logic [FILL_W-1:0]    fill_count;

    modport source(output valid, status, out_key, out_payload, fill_count, input ready);
    modport sink(input valid, status, out_key, out_payload, fill_count, output ready);
endinterface

`default_nettype wire

[sv/ksrs_cell.sv]
`default_nettype none

module ksrs_cell import ksrs_pkg::*; (
    input  wire logic             i_clk,
    input  wire t_cell_ctl        i_ctl,
    input  wire logic [IDX_W-1:0] i_rank,
    input  wire t_cell_data       i_above,
    input  wire t_cell_data       i_below,
    output t_cell_data            o_data
);

    t_cell_data r_data;
    t_cell_data n_data;

    always_comb begin
        n_data = r_data;
        case (i_ctl.op)
            CELL_HOLD: begin
                n_data = r_data;
            end
            CELL_SHIFT_DOWN: begin
                n_data = i_above;
            end
            CELL_SHIFT_UP: begin
                n_data = i_below;
            end
            CELL_LOAD_TAG: begin
                n_data.tag = i_rank;
            end
            CELL_SWAP: begin
                if (i_ctl.from_below) begin
                    n_data = i_below;
                end else if (i_ctl.from_above) begin
                    n_data = i_above;
                end
            end
            default: begin
                n_data = r_data;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;

endmodule

`default_nettype wire

[sv/keyed_stack_with_reverse_sort_unit.sv]
// Push, pop and peek results are registered from the transaction; the next transaction is
// taken while the output register is empty or its result is being read.
// Reverse and sort load a rank tag into every cell, then run STACK_DEPTH odd-even
// compare-and-swap phases across the cell chain, and no input is taken while they run.
// Reset (synchronous, active low) empties the stack and the output register; entry contents
// are not cleared.
`default_nettype none

module keyed_stack_with_reverse_sort_unit import ksrs_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    ksrs_in_if.sink    i_in,
    ksrs_out_if.source o_out
);

    t_state               r_state;
    t_state               n_state;
    logic [CNT_W-1:0]     r_count;
    logic [CNT_W-1:0]     n_count;
    logic [IDX_W-1:0]     r_pass;
    logic                 r_sort_mode;
    logic                 r_out_valid;
    logic [STATUS_W-1:0]  r_status;
    logic [KEY_W-1:0]     r_key;
    logic [PAYLOAD_W-1:0] r_payload;
    logic [FILL_W-1:0]    r_fill;

    logic                 in_fire;
    logic                 sort_done;
    logic                 load_out;
    logic                 is_full;
    logic                 is_empty;
    logic [STATUS_W-1:0]  res_status;
    logic [KEY_W-1:0]     res_key;
    logic [PAYLOAD_W-1:0] res_payload;
    logic [CNT_W+FILL_W-1:0] fill_ext;
    t_cell_op             chain_op;

    t_cell_data           cell_data [STACK_DEPTH];
    t_cell_ctl            cell_ctl  [STACK_DEPTH];
    logic [STACK_DEPTH-2:0] swap;
    t_cell_data           push_data;

    assign is_full   = (r_count == CNT_W'(STACK_DEPTH));
    assign is_empty  = (r_count == '0);
    assign in_fire   = i_in.valid && i_in.ready;
    assign sort_done = (r_state == S_SORT) && (r_pass == IDX_W'(STACK_DEPTH - 1));

    assign push_data.key     = i_in.entry_key;
    assign push_data.payload = i_in.entry_payload;
    assign push_data.tag     = '0;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_fire && (i_in.opcode == OP_REVERSE || i_in.opcode == OP_SORT)) begin
                    n_state = S_SORT;
                end
            end
            S_SORT: begin
                if (sort_done) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        i_in.ready = 1'b0;
        chain_op   = CELL_HOLD;
        load_out   = 1'b0;
        case (r_state)
            S_IDLE: begin
                i_in.ready = !r_out_valid || o_out.ready;
                if (in_fire) begin
                    load_out = (i_in.opcode != OP_REVERSE) && (i_in.opcode != OP_SORT);
                    case (i_in.opcode)
                        OP_PUSH:    chain_op = is_full ? CELL_HOLD : CELL_SHIFT_DOWN;
                        OP_POP:     chain_op = is_empty ? CELL_HOLD : CELL_SHIFT_UP;
                        OP_REVERSE: chain_op = CELL_LOAD_TAG;
                        OP_SORT:    chain_op = CELL_LOAD_TAG;
                        default:    chain_op = CELL_HOLD;
                    endcase
                end
            end
            S_SORT: begin
                chain_op = CELL_SWAP;
                load_out = sort_done;
            end
            default: begin
                chain_op = CELL_HOLD;
            end
        endcase
    end

    always_comb begin
        n_count = r_count;
        if (chain_op == CELL_SHIFT_DOWN) begin
            n_count = r_count + CNT_W'(1);
        end else if (chain_op == CELL_SHIFT_UP) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_comb begin
        res_status  = STAT_OK;
        res_key     = '0;
        res_payload = '0;
        if (r_state == S_IDLE) begin
            case (i_in.opcode)
                OP_PUSH: begin
                    if (is_full) begin
                        res_status = STAT_FULL;
                    end
                end
                OP_POP, OP_PEEK: begin
                    if (is_empty) begin
                        res_status = STAT_EMPTY;
                    end else begin
                        res_key     = cell_data[0].key;
                        res_payload = cell_data[0].payload;
                    end
                end
                default: begin
                    res_status = STAT_OK;
                end
            endcase
        end
    end

    assign fill_ext = {{FILL_W{1'b0}}, n_count};

    genvar p;
    generate
        for (p = 0; p < STACK_DEPTH - 1; p++) begin : g_pair
            logic [KEY_W+IDX_W-1:0] upper;
            logic [KEY_W+IDX_W-1:0] lower;
            assign upper = {r_sort_mode ? cell_data[p].key : {KEY_W{1'b0}}, cell_data[p].tag};
            assign lower = {r_sort_mode ? cell_data[p+1].key : {KEY_W{1'b0}},
                            cell_data[p+1].tag};
            assign swap[p] = (1'(p % 2) == r_pass[0]) && (CNT_W'(p + 1) < r_count)
                             && (upper > lower);
        end

        for (p = 0; p < STACK_DEPTH; p++) begin : g_cell
            t_cell_data above;
            t_cell_data below;

            if (p == 0) begin : g_top
                assign above = push_data;
            end else begin : g_mid_above
                assign above = cell_data[p-1];
            end

            if (p == STACK_DEPTH - 1) begin : g_bottom
                assign below = cell_data[p];
            end else begin : g_mid_below
                assign below = cell_data[p+1];
            end

            assign cell_ctl[p].op         = chain_op;
            assign cell_ctl[p].from_below = (p < STACK_DEPTH - 1) ? swap[(p < STACK_DEPTH - 1)
                                            ? p : 0] : 1'b0;
            assign cell_ctl[p].from_above = (p > 0) ? swap[(p > 0) ? p - 1 : 0] : 1'b0;

            ksrs_cell u_cell (
                .i_clk   (i_clk),
                .i_ctl   (cell_ctl[p]),
                .i_rank  (IDX_W'(STACK_DEPTH - 1 - p)),
                .i_above (above),
                .i_below (below),
                .o_data  (cell_data[p])
            );
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_pass      <= '0;
            r_sort_mode <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            if (chain_op == CELL_LOAD_TAG) begin
                r_pass      <= '0;
                r_sort_mode <= (i_in.opcode == OP_SORT);
            end else if (r_state == S_SORT) begin
                r_pass <= r_pass + IDX_W'(1);
            end
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_status  <= res_status;
            r_key     <= res_key;
            r_payload <= res_payload;
            r_fill    <= fill_ext[FILL_W-1:0];
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.status      = r_status;
    assign o_out.out_key     = r_key;
    assign o_out.out_payload = r_payload;
    assign o_out.fill_count  = r_fill;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(STACK_DEPTH))
        else $error("Entry count exceeds the stack depth.");

    a_no_accept_in_sort: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SORT) |-> !i_in.ready)
        else $error("Input transaction taken while a reorder runs.");

    a_count_stable_in_sort: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SORT) |=> $stable(r_count))
        else $error("Entry count changed during a reorder.");

    a_sort_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        sort_done |=> (r_out_valid && r_state == S_IDLE))
        else $error("Reorder finished without a result.");

    a_sort_out_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SORT) |-> !r_out_valid)
        else $error("Output register busy while a reorder runs.");

endmodule

`default_nettype wire

[dv/ksrs_result_checker.sv]
`default_nettype none

// Watches both channels, predicts the result of every accepted transaction and compares it
// with the next result that the block delivers.
module ksrs_result_checker import ksrs_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    ksrs_in_if        i_in,
    ksrs_out_if       i_out,
    output int        o_fail_count,
    output int        o_pending_count
);

    typedef struct {
        t_status              status;
        logic [KEY_W-1:0]     key;
        logic [PAYLOAD_W-1:0] payload;
        logic [FILL_W-1:0]    fill;
    } t_op_result;

    logic [KEY_W-1:0]     key_mem     [STACK_DEPTH];
    logic [PAYLOAD_W-1:0] payload_mem [STACK_DEPTH];
    int                   held;
    t_op_result           pending_results [$];
    t_op_result           want;
    bit                   bad;

    function automatic t_op_result apply_stack_op(input t_opcode op,
                                                  input logic [KEY_W-1:0] key,
                                                  input logic [PAYLOAD_W-1:0] payload);
        t_op_result           res;
        logic [KEY_W-1:0]     sorted_key     [STACK_DEPTH];
        logic [PAYLOAD_W-1:0] sorted_payload [STACK_DEPTH];
        logic [KEY_W-1:0]     tmp_key;
        logic [PAYLOAD_W-1:0] tmp_payload;
        int                   i;
        int                   j;
        res.status  = STAT_OK;
        res.key     = '0;
        res.payload = '0;
        case (op)
            OP_PUSH: begin
                if (held < STACK_DEPTH) begin
                    key_mem[held]     = key;
                    payload_mem[held] = payload;
                    held++;
                end else begin
                    res.status = STAT_FULL;
                end
            end
            OP_POP, OP_PEEK: begin
                if (held == 0) begin
                    res.status = STAT_EMPTY;
                end else begin
                    res.key     = key_mem[held-1];
                    res.payload = payload_mem[held-1];
                    if (op == OP_POP) begin
                        held--;
                    end
                end
            end
            OP_REVERSE: begin
                for (i = 0; i < held / 2; i++) begin
                    tmp_key                  = key_mem[i];
                    tmp_payload              = payload_mem[i];
                    key_mem[i]               = key_mem[held-1-i];
                    payload_mem[i]           = payload_mem[held-1-i];
                    key_mem[held-1-i]        = tmp_key;
                    payload_mem[held-1-i]    = tmp_payload;
                end
            end
            OP_SORT: begin
                // Stable ascending order from the bottom up, then stored so the smallest key
                // sits on top.
                for (i = 0; i < held; i++) begin
                    j = i;
                    while (j > 0 && sorted_key[j-1] > key_mem[i]) begin
                        sorted_key[j]     = sorted_key[j-1];
                        sorted_payload[j] = sorted_payload[j-1];
                        j--;
                    end
                    sorted_key[j]     = key_mem[i];
                    sorted_payload[j] = payload_mem[i];
                end
                for (i = 0; i < held; i++) begin
                    key_mem[i]     = sorted_key[held-1-i];
                    payload_mem[i] = sorted_payload[held-1-i];
                end
            end
            default: begin
            end
        endcase
        res.fill = FILL_W'(held);
        return res;
    endfunction

    function automatic bit field_differs(input string field,
                                         input logic [PAYLOAD_W-1:0] expected_value,
                                         input logic [PAYLOAD_W-1:0] actual_value);
        if (actual_value !== expected_value) begin
            $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h",
                     $time, field, expected_value, actual_value);
            return 1'b1;
        end
        return 1'b0;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            held = 0;
            pending_results.delete();
        end else begin
            if (i_out.valid && i_out.ready) begin
                if (pending_results.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual status %0d key 0x%0h payload 0x%0h fill %0d",
                             $time, i_out.status, i_out.out_key, i_out.out_payload,
                             i_out.fill_count);
                    o_fail_count++;
                end else begin
                    want = pending_results.pop_front();
                    bad  = field_differs("status", PAYLOAD_W'(want.status), PAYLOAD_W'(i_out.status))
                         | field_differs("out_key", PAYLOAD_W'(want.key), PAYLOAD_W'(i_out.out_key))
                         | field_differs("out_payload", want.payload, i_out.out_payload)
                         | field_differs("fill_count", PAYLOAD_W'(want.fill),
                                         PAYLOAD_W'(i_out.fill_count));
                    if (bad) begin
                        o_fail_count++;
                    end
                end
            end
            if (i_in.valid && i_in.ready) begin
                pending_results.push_back(apply_stack_op(t_opcode'(i_in.opcode), i_in.entry_key,
                                                         i_in.entry_payload));
            end
        end
        o_pending_count = pending_results.size();
    end

endmodule

`default_nettype wire

[dv/tb_top.sv]
`default_nettype none

module tb_top;
    import ksrs_pkg::*;

    localparam int ITEM_COUNT   = 2000;
    localparam int TAIL_START   = 1800;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = STACK_DEPTH + 8;

    typedef enum {
        MIX_FILL,
        MIX_DRAIN,
        MIX_EVEN
    } t_mix;

    logic i_clk;
    logic i_rst_n;
    int   fail_count;
    int   pending_count;
    int   cycle_count;
    bit   tail_phase;

    ksrs_in_if  in_ch ();
    ksrs_out_if out_ch ();

    keyed_stack_with_reverse_sort_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    ksrs_result_checker u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in            (in_ch),
        .i_out           (out_ch),
        .o_fail_count    (fail_count),
        .o_pending_count (pending_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial begin
        int run_left;
        bit run_ready;
        run_left     = 0;
        run_ready    = 1'b0;
        out_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (run_left == 0) begin
                run_ready = tail_phase || ($urandom_range(0, 2) != 0);
                run_left  = run_ready ? $urandom_range(1, 60) : $urandom_range(1, 14);
            end
            run_left--;
            out_ch.ready = run_ready || tail_phase;
        end
    end

    task automatic issue_op(input t_opcode op, input logic [KEY_W-1:0] key,
                            input logic [PAYLOAD_W-1:0] payload);
        in_ch.opcode        = op;
        in_ch.entry_key     = key;
        in_ch.entry_payload = payload;
        in_ch.valid         = 1'b1;
        @(posedge i_clk);
        while (!in_ch.ready) begin
            @(posedge i_clk);
        end
        @(negedge i_clk);
    endtask

    task automatic idle_cycles(input int count);
        in_ch.valid         = 1'b0;
        in_ch.opcode        = OP_W'($urandom_range(0, 4));
        in_ch.entry_key     = KEY_W'($urandom());
        in_ch.entry_payload = $urandom();
        repeat (count) @(negedge i_clk);
    endtask

    task automatic wait_drained();
        in_ch.valid = 1'b0;
        while (pending_count != 0) begin
            @(negedge i_clk);
        end
    endtask

    initial begin
        t_mix                 mix;
        int                   idle_pct;
        int                   push_pct;
        int                   pop_pct;
        int                   pick;
        int                   n;
        t_opcode              op;
        logic [KEY_W-1:0]     key;
        logic [PAYLOAD_W-1:0] payload;

        tail_phase          = 1'b0;
        in_ch.valid         = 1'b0;
        in_ch.opcode        = '0;
        in_ch.entry_key     = '0;
        in_ch.entry_payload = '0;
        i_rst_n             = 1'b0;
        mix                 = MIX_EVEN;
        idle_pct            = 0;
        push_pct            = 0;
        pop_pct             = 0;
        repeat (9) @(negedge i_clk);
        i_rst_n = 1'b1;

        issue_op(OP_POP, 8'hFF, 32'hFFFF_FFFF);
        issue_op(OP_PEEK, 8'h00, 32'h0);
        issue_op(OP_REVERSE, 8'h5A, 32'h1234_5678);
        issue_op(OP_SORT, 8'hA5, 32'h8765_4321);
        issue_op(OP_PUSH, 8'hFF, 32'hFFFF_FFFF);
        issue_op(OP_SORT, 8'h00, 32'h0);
        issue_op(OP_REVERSE, 8'h00, 32'h0);
        issue_op(OP_POP, 8'h00, 32'h0);
        for (n = 0; n <= STACK_DEPTH; n++) begin
            issue_op(OP_PUSH, (n == 5) ? 8'hFF : KEY_W'(n % 3),
                     (n == 0) ? 32'h0 : 32'hFFFF_FFFF - n);
        end
        issue_op(OP_SORT, 8'h00, 32'h0);
        issue_op(OP_REVERSE, 8'h00, 32'h0);
        wait_drained();

        for (n = 0; n < ITEM_COUNT; n++) begin
            if (n % 100 == 0) begin
                pick     = $urandom_range(0, 2);
                mix      = (pick == 0) ? MIX_FILL : (pick == 1) ? MIX_DRAIN : MIX_EVEN;
                pick     = $urandom_range(0, 2);
                idle_pct = (pick == 0) ? 0 : (pick == 1) ? 10 : 30;
                push_pct = (mix == MIX_FILL) ? 60 : (mix == MIX_DRAIN) ? 25 : 42;
                pop_pct  = (mix == MIX_DRAIN) ? 45 : 28;
            end
            if (n == ITEM_COUNT / 2) begin
                wait_drained();
            end
            tail_phase = (n >= TAIL_START);
            if (!tail_phase && $urandom_range(1, 100) <= idle_pct) begin
                idle_cycles($urandom_range(1, 14));
            end
            pick = $urandom_range(0, 99);
            if (pick < push_pct) begin
                op = OP_PUSH;
            end else if (pick < push_pct + pop_pct) begin
                op = OP_POP;
            end else if (pick < 86) begin
                op = OP_PEEK;
            end else if (pick < 93) begin
                op = OP_REVERSE;
            end else begin
                op = OP_SORT;
            end
            case ($urandom_range(0, 3))
                0: key = KEY_W'($urandom_range(0, 3));
                1: key = $urandom_range(0, 1) ? 8'hFF : 8'h00;
                default: key = KEY_W'($urandom_range(0, 255));
            endcase
            if ($urandom_range(0, 15) == 0) begin
                payload = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0;
            end else begin
                payload = $urandom();
            end
            issue_op(op, key, payload);
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (fail_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

`default_nettype wire
